// ===== sv/vir_pkg.sv =====
// ----------------------------------------------------------------------------
// vir_pkg: shared types and constants for the VAR impulse response block
// Sizes, item codes, controller states and the Q8.24 narrowing function.
// ----------------------------------------------------------------------------
package vir_pkg;

    localparam int MAX_VARS    = 8;
    localparam int MAX_LAGS    = 8;
    localparam int MAX_HORIZON = 16;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 72;
    localparam int FRAC_W     = 24;
    localparam int VAR_W      = $clog2(MAX_VARS);
    localparam int COL_W      = 6;
    localparam int STEP_W     = 5;
    localparam int COEF_DEPTH = MAX_VARS * MAX_VARS * MAX_LAGS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int RESP_DEPTH = (MAX_HORIZON + 1) * MAX_VARS * MAX_VARS;
    localparam int RESP_AW    = STEP_W + 2 * VAR_W;

    localparam logic [DATA_W-1:0] ONE_Q24 = 32'h0100_0000;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_COMPUTE = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_PENDING = 2'd2,
        STAT_SAT     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_NUM_VARS = 2'd0,
        CFG_NUM_LAGS = 2'd1,
        CFG_HORIZON  = 2'd2,
        CFG_SPARE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_INIT,
        ST_FILL,
        ST_WAIT,
        ST_MAC,
        ST_ADD,
        ST_LATCH,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Strobes from the controller to every cell of the chain
    typedef struct packed {
        logic clr;
        logic shift_b;
        logic mul;
        logic add;
        logic latch;
        logic shift_res;
    } cell_ctl_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } sat_word_t;

    // Floor shift by FRAC_W and saturate to DATA_W bits
    function automatic sat_word_t narrow_acc(input logic [ACC_W-1:0] acc);
        sat_word_t res;
        logic [ACC_W-FRAC_W-DATA_W:0] top;
        top = acc[ACC_W-1:FRAC_W+DATA_W-1];
        if ((top == '0) || (top == '1)) begin
            res.sat = 1'b0;
            res.val = acc[FRAC_W+DATA_W-1:FRAC_W];
        end else begin
            res.sat = 1'b1;
            res.val = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== sv/var_impulse_response.sv =====
// ----------------------------------------------------------------------------
// var_impulse_response: VAR moving-average impulse response engine
// Stores lag coefficient matrices, computes Phi_1..Phi_h on a chain of column
// cells and answers element reads from the response memory.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | tuser: kind; tdata: row, col, step, coef_value
//  m_       | out       | tuser: status; tdata: result_value
//  cfg_     | in        | cfg_index, cfg_data (always ready)
//
// Load and bad items are answered straight from the idle state; reads add a
// registered response memory read (ST_READ). Compute seeds Phi_0, then for each row
// of Phi_1..Phi_h runs FILL, WAIT and MAC per product term, then ADD, LATCH, WRITEs.
// After reset a pass over all 512 coefficient words clears that memory; no item is taken.
// One item at a time; a result not yet taken holds off the next item.
// ----------------------------------------------------------------------------
module var_impulse_response (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row_index[2:0], col_index[8:3], step_index[13:9],
                                   // coef_value[45:14], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value[31:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int DW = vir_pkg::DATA_W;
    localparam int VW = vir_pkg::VAR_W;
    localparam int NC = vir_pkg::MAX_VARS;

    // Configuration and flags
    logic [3:0] num_vars_reg, num_lags_reg;
    logic [4:0] horizon_reg;
    logic       computed_reg, sat_reg, sat_acc_reg;

    // Controller
    vir_pkg::state_t state_reg, state_next;
    logic [vir_pkg::COEF_AW-1:0] clr_cnt_reg;
    logic [4:0]    i_reg;
    logic [VW-1:0] r_reg, c_reg, fc_reg, k_reg;
    logic [3:0]    j_reg;
    logic [5:0]    lag_reg;
    logic          fill_dly_reg, afill_dly_reg, mul_dly_reg;

    // Memories
    logic [DW-1:0] coef_mem [vir_pkg::COEF_DEPTH];
    logic [DW-1:0] resp_mem [vir_pkg::RESP_DEPTH];
    logic [DW-1:0] coef_rdata_reg, resp_rdata_reg;
    logic signed [DW-1:0] a_reg;
    logic                        coef_we, resp_we;
    logic [vir_pkg::COEF_AW-1:0] coef_wa, coef_ra;
    logic [DW-1:0]               coef_wd, resp_wd;
    logic [vir_pkg::RESP_AW-1:0] resp_wa, resp_ra;

    // Output register
    logic          m_valid_reg;
    logic [DW-1:0] m_data_reg;
    logic [1:0]    m_user_reg;
    logic          out_load;
    logic [DW-1:0] out_data;
    vir_pkg::status_t out_stat;

    // Chain
    vir_pkg::cell_ctl_t ctl;
    logic signed [DW-1:0] b_chain [NC+1];
    logic [DW-1:0]        res_chain [NC+1];
    logic                 sat_chain [NC+1];

    // Item fields
    vir_pkg::kind_t in_kind;
    logic [2:0]  in_row;
    logic [5:0]  in_col;
    logic [4:0]  in_step;
    logic [31:0] in_coef;
    logic        in_acc;
    assign in_kind = vir_pkg::kind_t'(s_tuser);
    assign in_row  = s_tdata[2:0];
    assign in_col  = s_tdata[8:3];
    assign in_step = s_tdata[13:9];
    assign in_coef = s_tdata[45:14];
    assign in_acc  = s_tvalid && s_tready;

    // Clamped register values
    logic [3:0] n_eff, p_eff, pe, jmax;
    logic [4:0] h_eff;
    logic [6:0] np;
    assign n_eff = (num_vars_reg == 4'd0) ? 4'd1 :
                   (num_vars_reg > 4'(NC)) ? 4'(NC) : num_vars_reg;
    assign p_eff = (num_lags_reg == 4'd0) ? 4'd1 :
                   (num_lags_reg > 4'(vir_pkg::MAX_LAGS)) ? 4'(vir_pkg::MAX_LAGS) : num_lags_reg;
    assign h_eff = (horizon_reg == 5'd0) ? 5'd1 :
                   (horizon_reg > 5'(vir_pkg::MAX_HORIZON)) ? 5'(vir_pkg::MAX_HORIZON)
                                                            : horizon_reg;
    assign pe    = ({1'b0, p_eff} < h_eff) ? p_eff : h_eff[3:0];
    assign jmax  = (i_reg < {1'b0, pe}) ? i_reg[3:0] : pe;
    assign np    = 7'(n_eff * p_eff);

    logic [3:0] n_m1;
    logic       last_c, last_r, last_k, last_fc;
    logic       load_ok, read_ok;
    assign n_m1    = n_eff - 4'd1;
    assign last_c  = ({1'b0, c_reg} == n_m1);
    assign last_r  = ({1'b0, r_reg} == n_m1);
    assign last_k  = ({1'b0, k_reg} == n_m1);
    assign last_fc = (fc_reg == '0);
    assign load_ok = ({1'b0, in_row} < n_eff) && ({1'b0, in_col} < np);
    assign read_ok = ({1'b0, in_row} < n_eff) && (in_col < {2'b00, n_eff}) && (in_step <= h_eff);

    assign s_tready  = (state_reg == vir_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vir_pkg::ST_CLEAR: if (clr_cnt_reg == '1) state_next = vir_pkg::ST_IDLE;
            vir_pkg::ST_IDLE: begin
                if (in_acc && in_kind == vir_pkg::KIND_COMPUTE) begin
                    state_next = vir_pkg::ST_INIT;
                end else if (in_acc && in_kind == vir_pkg::KIND_READ && read_ok
                             && computed_reg) begin
                    state_next = vir_pkg::ST_READ;
                end
            end
            vir_pkg::ST_READ:  state_next = vir_pkg::ST_IDLE;
            vir_pkg::ST_INIT:  if (last_r && last_c) state_next = vir_pkg::ST_FILL;
            vir_pkg::ST_FILL:  if (last_fc) state_next = vir_pkg::ST_WAIT;
            vir_pkg::ST_WAIT:  state_next = vir_pkg::ST_MAC;
            vir_pkg::ST_MAC: begin
                state_next = (last_k && j_reg == jmax) ? vir_pkg::ST_ADD : vir_pkg::ST_FILL;
            end
            vir_pkg::ST_ADD:   state_next = vir_pkg::ST_LATCH;
            vir_pkg::ST_LATCH: state_next = vir_pkg::ST_WRITE;
            vir_pkg::ST_WRITE: begin
                if (last_c) begin
                    state_next = (last_r && i_reg == h_eff) ? vir_pkg::ST_DONE
                                                            : vir_pkg::ST_FILL;
                end
            end
            vir_pkg::ST_DONE:  state_next = vir_pkg::ST_IDLE;
            default:           state_next = vir_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs: memory ports, cell strobes, result loads
    always_comb begin
        coef_we  = 1'b0;
        coef_wa  = {in_row, in_col};
        coef_wd  = in_coef;
        coef_ra  = {k_reg, 6'(lag_reg + {3'b000, fc_reg})};
        resp_we  = 1'b0;
        resp_wa  = {i_reg, r_reg, c_reg};
        resp_wd  = res_chain[0];
        resp_ra  = {in_step, in_row, in_col[VW-1:0]};
        out_load = 1'b0;
        out_data = '0;
        out_stat = vir_pkg::STAT_RANGE;
        ctl      = '0;
        ctl.shift_b = fill_dly_reg;
        ctl.add     = mul_dly_reg;
        case (state_reg)
            vir_pkg::ST_CLEAR: begin
                coef_we = 1'b1;
                coef_wa = clr_cnt_reg;
                coef_wd = '0;
            end
            vir_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_kind)
                        vir_pkg::KIND_LOAD: begin
                            coef_we  = load_ok;
                            out_load = 1'b1;
                            out_stat = load_ok ? vir_pkg::STAT_OK : vir_pkg::STAT_RANGE;
                        end
                        vir_pkg::KIND_READ: begin
                            out_load = !(read_ok && computed_reg);
                            out_stat = read_ok ? vir_pkg::STAT_PENDING : vir_pkg::STAT_RANGE;
                        end
                        vir_pkg::KIND_COMPUTE: ctl.clr = 1'b1;
                        default:               out_load = 1'b1;
                    endcase
                end
            end
            vir_pkg::ST_READ: begin
                out_load = 1'b1;
                out_data = resp_rdata_reg;
                out_stat = sat_reg ? vir_pkg::STAT_SAT : vir_pkg::STAT_OK;
            end
            vir_pkg::ST_INIT: begin
                resp_we = 1'b1;
                resp_wa = {5'd0, r_reg, c_reg};
                resp_wd = (r_reg == c_reg) ? vir_pkg::ONE_Q24 : '0;
            end
            vir_pkg::ST_FILL: begin
                resp_ra = {5'(i_reg - {1'b0, j_reg}), r_reg, k_reg};
            end
            vir_pkg::ST_MAC:   ctl.mul = 1'b1;
            vir_pkg::ST_LATCH: ctl.latch = 1'b1;
            vir_pkg::ST_WRITE: begin
                resp_we       = 1'b1;
                ctl.shift_res = 1'b1;
            end
            vir_pkg::ST_DONE: begin
                out_load = 1'b1;
                out_stat = sat_acc_reg ? vir_pkg::STAT_SAT : vir_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    // State, counters and delay flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vir_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            fill_dly_reg  <= 1'b0;
            afill_dly_reg <= 1'b0;
            mul_dly_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_dly_reg  <= (state_reg == vir_pkg::ST_FILL);
            afill_dly_reg <= (state_reg == vir_pkg::ST_FILL) && ({1'b0, fc_reg} == n_m1);
            mul_dly_reg   <= (state_reg == vir_pkg::ST_MAC);
            if (state_reg == vir_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Loop indexes of the recursion
    always_ff @(posedge aclk) begin
        case (state_reg)
            vir_pkg::ST_IDLE: begin
                r_reg       <= '0;
                c_reg       <= '0;
                sat_acc_reg <= 1'b0;
            end
            vir_pkg::ST_INIT: begin
                c_reg <= last_c ? '0 : c_reg + 1'b1;
                if (last_c) r_reg <= last_r ? '0 : r_reg + 1'b1;
                i_reg   <= 5'd1;
                j_reg   <= 4'd1;
                k_reg   <= '0;
                lag_reg <= '0;
                fc_reg  <= n_m1[VW-1:0];
            end
            vir_pkg::ST_FILL: fc_reg <= fc_reg - 1'b1;
            vir_pkg::ST_MAC: begin
                fc_reg <= n_m1[VW-1:0];
                if (last_k) begin
                    k_reg   <= '0;
                    j_reg   <= j_reg + 1'b1;
                    lag_reg <= lag_reg + {2'b00, n_eff};
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            vir_pkg::ST_WRITE: begin
                sat_acc_reg <= sat_acc_reg | sat_chain[0];
                c_reg       <= last_c ? '0 : c_reg + 1'b1;
                if (last_c) begin
                    r_reg <= last_r ? '0 : r_reg + 1'b1;
                    if (last_r) i_reg <= i_reg + 1'b1;
                end
                j_reg   <= 4'd1;
                k_reg   <= '0;
                lag_reg <= '0;
                fc_reg  <= n_m1[VW-1:0];
            end
            default: ;
        endcase
    end

    // Configuration registers and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg <= 4'd1;
            num_lags_reg <= 4'd1;
            horizon_reg  <= 5'd5;
            computed_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (vir_pkg::cfg_idx_t'(cfg_index))
                    vir_pkg::CFG_NUM_VARS: begin
                        num_vars_reg <= cfg_data[3:0];
                        computed_reg <= 1'b0;
                    end
                    vir_pkg::CFG_NUM_LAGS: begin
                        num_lags_reg <= cfg_data[3:0];
                        computed_reg <= 1'b0;
                    end
                    vir_pkg::CFG_HORIZON: begin
                        horizon_reg  <= cfg_data;
                        computed_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (coef_we && state_reg == vir_pkg::ST_IDLE) begin
                computed_reg <= 1'b0;
            end
            if (state_reg == vir_pkg::ST_DONE) begin
                computed_reg <= 1'b1;
                sat_reg      <= sat_acc_reg;
            end
        end
    end

    // Coefficient memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (coef_we) coef_mem[coef_wa] <= coef_wd;
        coef_rdata_reg <= coef_mem[coef_ra];
    end

    // Response memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (resp_we) resp_mem[resp_wa] <= resp_wd;
        resp_rdata_reg <= resp_mem[resp_ra];
    end

    // Hold the response element broadcast to the chain
    always_ff @(posedge aclk) begin
        if (afill_dly_reg) a_reg <= resp_rdata_reg;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
            m_user_reg <= out_stat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Chain of column cells
    assign b_chain[0]    = coef_rdata_reg;
    assign res_chain[NC] = '0;
    assign sat_chain[NC] = 1'b0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        vir_cell u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .a_in    (a_reg),
            .b_in    (b_chain[g]),
            .res_in  (res_chain[g+1]),
            .sat_in  (sat_chain[g+1]),
            .b_out   (b_chain[g+1]),
            .res_out (res_chain[g]),
            .sat_out (sat_chain[g])
        );
    end

    // Checks
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vir_pkg::ST_READ || state_reg == vir_pkg::ST_DONE)
            |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == vir_pkg::ST_FILL |-> ({1'b0, fc_reg} < n_eff))
        else $error("fill counter beyond matrix size");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != vir_pkg::ST_IDLE && state_reg != vir_pkg::ST_CLEAR) |-> !coef_we)
        else $error("coefficient write during compute");

    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == vir_pkg::ST_DONE |=> computed_reg)
        else $error("computed flag not set");

endmodule

// ===== sv/vir_cell.sv =====
// ----------------------------------------------------------------------------
// vir_cell: one column cell of the multiply-accumulate chain
// Holds a coefficient passed along the chain, multiplies it by the broadcast
// response element, accumulates and hands its narrowed result to its neighbor.
// ----------------------------------------------------------------------------
module vir_cell (
    input  logic                                aclk,
    input  vir_pkg::cell_ctl_t                  ctl,
    input  logic signed [vir_pkg::DATA_W-1:0]   a_in,
    input  logic signed [vir_pkg::DATA_W-1:0]   b_in,
    input  logic        [vir_pkg::DATA_W-1:0]   res_in,
    input  logic                                sat_in,
    output logic signed [vir_pkg::DATA_W-1:0]   b_out,
    output logic        [vir_pkg::DATA_W-1:0]   res_out,
    output logic                                sat_out
);

    logic signed [vir_pkg::DATA_W-1:0] b_reg;
    logic signed [vir_pkg::PROD_W-1:0] prod_reg;
    logic        [vir_pkg::ACC_W-1:0]  acc_reg;
    logic        [vir_pkg::DATA_W-1:0] res_reg;
    logic                              sat_reg;
    vir_pkg::sat_word_t                narrow;

    assign narrow = vir_pkg::narrow_acc(acc_reg);

    // Shift coefficient, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (ctl.shift_b) begin
            b_reg <= b_in;
        end
        if (ctl.mul) begin
            prod_reg <= a_in * b_reg;
        end
        if (ctl.clr || ctl.latch) begin
            acc_reg <= '0;
        end else if (ctl.add) begin
            acc_reg <= acc_reg + {{(vir_pkg::ACC_W-vir_pkg::PROD_W){prod_reg[vir_pkg::PROD_W-1]}},
                                  prod_reg};
        end
    end

    // Capture the narrowed sum, then shift results toward the chain head
    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            res_reg <= narrow.val;
            sat_reg <= narrow.sat;
        end else if (ctl.shift_res) begin
            res_reg <= res_in;
            sat_reg <= sat_in;
        end
    end

    assign b_out   = b_reg;
    assign res_out = res_reg;
    assign sat_out = sat_reg;

endmodule

// ===== tb/vir_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vir_checker: response predictor and scoreboard for var_impulse_response
// Watches the config, input and result channels, keeps its own copy of the
// coefficient and response matrices, predicts one result per accepted item
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module vir_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [31:0]      value;
        vir_pkg::status_t status;
    } answer_t;

    logic [3:0]  vars_reg;
    logic [3:0]  lags_reg;
    logic [4:0]  hor_reg;
    logic [31:0] coefs [0:vir_pkg::MAX_VARS-1][0:vir_pkg::MAX_VARS*vir_pkg::MAX_LAGS-1];
    logic [31:0] phi   [0:vir_pkg::MAX_HORIZON][0:vir_pkg::MAX_VARS-1][0:vir_pkg::MAX_VARS-1];
    logic        have_phi;
    logic        phi_sat;
    answer_t     answers [$];

    assign pending = answers.size();

    function automatic int clampv(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Rebuild Phi_0..Phi_h; returns 1 when any element clipped
    function automatic logic rebuild_phi();
        int n, p, h, pe, jm;
        logic signed [127:0] acc;
        logic signed [127:0] lim;
        longint a, b, prod;
        logic clipped;
        n = clampv(vars_reg, vir_pkg::MAX_VARS);
        p = clampv(lags_reg, vir_pkg::MAX_LAGS);
        h = clampv(hor_reg, vir_pkg::MAX_HORIZON);
        pe = (p < h) ? p : h;
        lim = 128'sd1 <<< 55;
        clipped = 1'b0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                phi[0][r][c] = (r == c) ? vir_pkg::ONE_Q24 : 32'd0;
        for (int i = 1; i <= h; i++) begin
            jm = (i < pe) ? i : pe;
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    acc = '0;
                    for (int j = 1; j <= jm; j++) begin
                        for (int k = 0; k < n; k++) begin
                            a = longint'($signed(phi[i-j][r][k]));
                            b = longint'($signed(coefs[k][(j-1)*n+c]));
                            prod = a * b;
                            acc = acc + {{64{prod[63]}}, prod};
                        end
                    end
                    if (acc >= -lim && acc < lim) begin
                        phi[i][r][c] = acc[55:24];
                    end else begin
                        clipped = 1'b1;
                        phi[i][r][c] = acc[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                end
            end
        end
        return clipped;
    endfunction

    // Apply one item to the shadow state and return its expected answer
    function automatic answer_t apply_item(vir_pkg::kind_t kind, int row, int col, int stp,
                                           logic [31:0] val);
        answer_t ans;
        int n, p, h;
        n = clampv(vars_reg, vir_pkg::MAX_VARS);
        p = clampv(lags_reg, vir_pkg::MAX_LAGS);
        h = clampv(hor_reg, vir_pkg::MAX_HORIZON);
        ans.value = '0;
        ans.status = vir_pkg::STAT_RANGE;
        case (kind)
            vir_pkg::KIND_LOAD: begin
                if (row < n && col < n * p) begin
                    coefs[row][col] = val;
                    have_phi = 1'b0;
                    ans.status = vir_pkg::STAT_OK;
                end
            end
            vir_pkg::KIND_COMPUTE: begin
                phi_sat = rebuild_phi();
                have_phi = 1'b1;
                ans.status = phi_sat ? vir_pkg::STAT_SAT : vir_pkg::STAT_OK;
            end
            vir_pkg::KIND_READ: begin
                if (row >= n || col >= n || stp > h) begin
                    ans.status = vir_pkg::STAT_RANGE;
                end else if (!have_phi) begin
                    ans.status = vir_pkg::STAT_PENDING;
                end else begin
                    ans.value = phi[stp][row][col];
                    ans.status = phi_sat ? vir_pkg::STAT_SAT : vir_pkg::STAT_OK;
                end
            end
            default: ans.status = vir_pkg::STAT_RANGE;
        endcase
        return ans;
    endfunction

    // Track config writes, predict on input items, compare on result items
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            vars_reg = 4'd1;
            lags_reg = 4'd1;
            hor_reg  = 5'd5;
            have_phi = 1'b0;
            phi_sat  = 1'b0;
            errors   <= 0;
            for (int r = 0; r < vir_pkg::MAX_VARS; r++)
                for (int c = 0; c < vir_pkg::MAX_VARS * vir_pkg::MAX_LAGS; c++)
                    coefs[r][c] = '0;
            answers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result value=%h status=%0d",
                             $time, m_tdata, m_tuser);
                    errors <= errors + 1;
                end else begin
                    want = answers.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.status) begin
                        $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                                 $time, want.value, want.status, m_tdata, m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (vir_pkg::cfg_idx_t'(cfg_index))
                    vir_pkg::CFG_NUM_VARS: begin vars_reg = cfg_data[3:0]; have_phi = 1'b0; end
                    vir_pkg::CFG_NUM_LAGS: begin lags_reg = cfg_data[3:0]; have_phi = 1'b0; end
                    vir_pkg::CFG_HORIZON:  begin hor_reg  = cfg_data;      have_phi = 1'b0; end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                answers.push_back(apply_item(vir_pkg::kind_t'(s_tuser), s_tdata[2:0],
                                             s_tdata[8:3], s_tdata[13:9], s_tdata[45:14]));
            end
        end
    end

endmodule

// ===== tb/tb_var_impulse_response.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_var_impulse_response: stimulus and verdict for var_impulse_response
// Runs directed corner items, then random phases that configure the matrix
// sizes, load full coefficient sets, compute and read back responses, mixed
// with malformed items, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_var_impulse_response;

    localparam int IDLE_LIMIT = 500000;
    localparam int ITEM_GOAL  = 1450;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    int   errors;
    int   pending;
    int   items_sent = 0;
    int   computes_sent = 0;
    int   reads_sent = 0;
    int   idle_cycles = 0;
    int   hold_left = 0;
    logic calm = 1'b0;
    logic squeeze_req = 1'b0;
    logic squeeze_seen = 1'b0;

    always #6 aclk = ~aclk;

    var_impulse_response uut (.*);

    vir_checker chk (.*);

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        squeeze_seen <= squeeze_req;
        if (squeeze_req != squeeze_seen) begin
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one item and hold it until accepted
    task automatic send(vir_pkg::kind_t kind, int row, int col, int stp, logic [31:0] val);
        while (!calm && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, val, stp[4:0], col[5:0], row[2:0]};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (kind == vir_pkg::KIND_COMPUTE) computes_sent++;
        if (kind == vir_pkg::KIND_READ) reads_sent++;
    endtask

    // Drain all results, then write the three size registers
    task automatic set_sizes(int nv, int nl, int hz);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? vir_pkg::CFG_NUM_VARS :
                         (i == 1) ? vir_pkg::CFG_NUM_LAGS : vir_pkg::CFG_HORIZON;
            cfg_data  <= (i == 0) ? nv[4:0] : (i == 1) ? nl[4:0] : hz[4:0];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly modest coefficients, sometimes any 32-bit word
    function automatic logic [31:0] pick_coef(int nv);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000) / nv;
    endfunction

    // Malformed or out-of-range item with random fields
    task automatic send_noise();
        send(vir_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 7),
             $urandom_range(0, 63), $urandom_range(0, 31), $urandom);
    endtask

    // One configure / load / compute / read pass; optionally stall the receiver
    // while the loads keep coming
    task automatic run_phase(int nv, int nl, int hz, int n_reads, bit squeeze);
        int n, p, h;
        n = (nv < 1) ? 1 : (nv > vir_pkg::MAX_VARS) ? vir_pkg::MAX_VARS : nv;
        p = (nl < 1) ? 1 : (nl > vir_pkg::MAX_LAGS) ? vir_pkg::MAX_LAGS : nl;
        h = (hz < 1) ? 1 : (hz > vir_pkg::MAX_HORIZON) ? vir_pkg::MAX_HORIZON : hz;
        set_sizes(nv, nl, hz);
        if (squeeze) squeeze_req <= ~squeeze_req;
        send(vir_pkg::KIND_READ, 0, 0, 0, $urandom);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n * p; c++) begin
                send(vir_pkg::KIND_LOAD, r, c, $urandom_range(0, 31), pick_coef(n));
                if ($urandom_range(0, 19) == 0) send_noise();
            end
        end
        send(vir_pkg::KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 63),
             $urandom_range(0, 31), $urandom);
        for (int k = 0; k < n_reads; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send(vir_pkg::KIND_READ, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     $urandom_range(0, h), $urandom);
        end
    endtask

    initial begin
        int phase;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default sizes, nothing computed yet
        send(vir_pkg::KIND_READ, 0, 0, 0, 32'h0);
        send(vir_pkg::KIND_NONE, 7, 63, 31, 32'hFFFF_FFFF);
        send(vir_pkg::KIND_LOAD, 1, 0, 0, 32'h1234_5678);
        send(vir_pkg::KIND_LOAD, 0, 1, 0, 32'h1234_5678);
        send(vir_pkg::KIND_LOAD, 0, 0, 0, 32'h0080_0000);
        send(vir_pkg::KIND_COMPUTE, 0, 0, 0, 32'h0);
        send(vir_pkg::KIND_READ, 0, 0, 5, 32'h0);
        send(vir_pkg::KIND_READ, 0, 0, 6, 32'h0);
        send(vir_pkg::KIND_READ, 0, 1, 1, 32'h0);
        send(vir_pkg::KIND_LOAD, 0, 0, 0, 32'hFFC0_0000);
        send(vir_pkg::KIND_READ, 0, 0, 1, 32'h0);

        // Directed: extreme coefficients force saturation
        set_sizes(2, 2, 3);
        send(vir_pkg::KIND_LOAD, 0, 0, 0, 32'h7FFF_FFFF);
        send(vir_pkg::KIND_LOAD, 1, 3, 0, 32'h8000_0000);
        send(vir_pkg::KIND_LOAD, 0, 1, 0, 32'h8000_0000);
        send(vir_pkg::KIND_LOAD, 1, 2, 0, 32'h7FFF_FFFF);
        send(vir_pkg::KIND_LOAD, 1, 4, 0, 32'h0);
        send(vir_pkg::KIND_COMPUTE, 0, 0, 0, 32'h0);
        send(vir_pkg::KIND_READ, 0, 0, 3, 32'h0);
        send(vir_pkg::KIND_READ, 1, 1, 2, 32'h0);
        send(vir_pkg::KIND_READ, 1, 0, 0, 32'h0);
        send(vir_pkg::KIND_READ, 2, 0, 0, 32'h0);
        send(vir_pkg::KIND_READ, 0, 2, 0, 32'h0);
        send(vir_pkg::KIND_READ, 0, 0, 4, 32'h0);

        // Register extremes: zero clamps up, all ones clamps to the maximum
        run_phase(0, 0, 0, 6, 1'b0);
        run_phase(15, 15, 31, 20, 1'b0);

        // Random phases over small and medium sizes
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            calm = (phase == 4);
            if (phase == 7)
                run_phase(1, 8, 16, 25, 1'b0);
            else
                run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 10),
                          $urandom_range(10, 30), phase == 2);
            phase++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain and let the block settle
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d items (%0d computes, %0d reads) over %0d random phases;",
                 items_sent, computes_sent, reads_sent, phase);
        $display("sizes from 1x1 up to 8 vars, 8 lags, horizon 16, with stalls and noise.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
